@@ rtl/core/att_pkg.sv @@
package att_pkg;

	// Width of a calibration offset register.
	localparam int OFS_W = 10;
	// Width of the CORDIC angle accumulator, degrees with FRAC fractional bits.
	localparam int ZW = 25;
	localparam int FRAC = 16;
	// Width of an output angle in whole degrees.
	localparam int DEG_W = 8;
	localparam int ATAN_LEN = 24;

	localparam logic signed [DEG_W-1:0] DEG_POS = 8'sd90;
	localparam logic signed [DEG_W-1:0] DEG_NEG = -8'sd90;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_OFS_X = 2'd0,
		REG_OFS_Y = 2'd1,
		REG_OFS_Z = 2'd2
	} reg_idx_t;

	// Angle of one CORDIC micro-rotation, atan(2^-i) in degrees scaled by 2^16.
	function automatic logic signed [ZW-1:0] atan_q16(input int i);
		logic signed [ZW-1:0] r;
		begin
			case (i)
				0: r = 25'sd2949120;
				1: r = 25'sd1740967;
				2: r = 25'sd919879;
				3: r = 25'sd466945;
				4: r = 25'sd234379;
				5: r = 25'sd117304;
				6: r = 25'sd58666;
				7: r = 25'sd29335;
				8: r = 25'sd14668;
				9: r = 25'sd7334;
				10: r = 25'sd3667;
				11: r = 25'sd1833;
				12: r = 25'sd917;
				13: r = 25'sd458;
				14: r = 25'sd229;
				15: r = 25'sd115;
				16: r = 25'sd57;
				17: r = 25'sd29;
				18: r = 25'sd14;
				19: r = 25'sd7;
				20: r = 25'sd4;
				21: r = 25'sd2;
				22: r = 25'sd1;
				default: r = 25'sd0;
			endcase
			return r;
		end
	endfunction

endpackage

@@ rtl/core/att_sqrt_cell.sv @@
// One digit of a restoring square root: takes two radicand bits, yields one root bit.
module att_sqrt_cell #(
	parameter int QB = 22,
	parameter int SW = 23
) (
	input  logic            clk,
	input  logic            en,
	input  logic [QB+1:0]   rem_i,
	input  logic [QB-1:0]   root_i,
	input  logic [2*QB-1:0] rad_i,
	input  logic [SW-1:0]   side_i,
	output logic [QB+1:0]   rem_q,
	output logic [QB-1:0]   root_q,
	output logic [2*QB-1:0] rad_q,
	output logic [SW-1:0]   side_q
);

	logic [QB+1:0] r_sh;
	logic [QB+1:0] trial;
	logic          ge;

	// Bring down the next two radicand bits and try the next root bit.
	always_comb begin
		r_sh  = {rem_i[QB-1:0], rad_i[2*QB-1 -: 2]};
		trial = {root_i, 2'b01};
		ge    = (r_sh >= trial);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? (r_sh - trial) : r_sh;
			root_q <= {root_i[QB-2:0], ge};
			rad_q  <= {rad_i[2*QB-3:0], 2'b00};
			side_q <= side_i;
		end
	end

endmodule

@@ rtl/core/att_cordic_cell.sv @@
// One vectoring-mode CORDIC micro-rotation with a fixed shift.
module att_cordic_cell #(
	parameter int W = 24,
	parameter int IDX = 0,
	parameter int SW = 9
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [W-1:0]           x_i,
	input  logic signed [W-1:0]           y_i,
	input  logic signed [att_pkg::ZW-1:0] z_i,
	input  logic [SW-1:0]                 side_i,
	output logic signed [W-1:0]           x_q,
	output logic signed [W-1:0]           y_q,
	output logic signed [att_pkg::ZW-1:0] z_q,
	output logic [SW-1:0]                 side_q
);

	localparam logic signed [att_pkg::ZW-1:0] ANG = att_pkg::atan_q16(IDX);

	logic signed [W-1:0] xs;
	logic signed [W-1:0] ys;

	// Arithmetic shifts round toward minus infinity.
	always_comb begin
		xs = x_i >>> IDX;
		ys = y_i >>> IDX;
	end

	// Rotate toward the x axis and track the angle.
	always_ff @(posedge clk) begin
		if (en) begin
			if (y_i > 0) begin
				x_q <= x_i + ys;
				y_q <= y_i - xs;
				z_q <= z_i + ANG;
			end else begin
				x_q <= x_i - ys;
				y_q <= y_i + xs;
				z_q <= z_i - ANG;
			end
			side_q <= side_i;
		end
	end

endmodule

@@ rtl/core/att_lane.sv @@
// One tilt angle: atan2(a, sqrt(b^2 + c^2)) through a square root chain and a CORDIC chain.
module att_lane #(
	parameter int DW = 14,
	parameter int CS = 16
) (
	input  logic                             clk,
	input  logic [DW+8+CS+2:1]               en,
	input  logic signed [DW-1:0]             a,
	input  logic signed [DW-1:0]             b,
	input  logic signed [DW-1:0]             c,
	output logic signed [att_pkg::DEG_W-1:0] deg_q
);

	localparam int QB = DW + 8;
	localparam int W = QB + 2;
	localparam int LAST = QB + CS + 2;
	localparam int SPW = 1 + att_pkg::DEG_W;
	localparam int SW = SPW + DW;
	localparam int ZW = att_pkg::ZW;

	logic signed [2*DW-1:0] pb;
	logic signed [2*DW-1:0] pc;
	logic [2*DW-1:0]        den;
	logic [SPW-1:0]         spec;

	logic [2*QB-1:0]        rad_s1;
	logic [SW-1:0]          side_s1;

	// Squares of the two other axes and the zero-denominator result.
	always_comb begin
		pb  = b * b;
		pc  = c * c;
		den = unsigned'(pb) + unsigned'(pc);
		spec[SPW-1] = (den == '0);
		if (a > 0) begin
			spec[SPW-2:0] = att_pkg::DEG_POS;
		end else if (a < 0) begin
			spec[SPW-2:0] = att_pkg::DEG_NEG;
		end else begin
			spec[SPW-2:0] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			rad_s1  <= {den, {att_pkg::FRAC{1'b0}}};
			side_s1 <= {spec, a};
		end
	end

	// Square root chain of QB cells.
	logic [QB+1:0]   rem_c  [QB+1];
	logic [QB-1:0]   root_c [QB+1];
	logic [2*QB-1:0] rad_c  [QB+1];
	logic [SW-1:0]   sside_c [QB+1];

	assign rem_c[0]   = '0;
	assign root_c[0]  = '0;
	assign rad_c[0]   = rad_s1;
	assign sside_c[0] = side_s1;

	for (genvar k = 0; k < QB; k++) begin : g_sqrt
		att_sqrt_cell #(.QB(QB), .SW(SW)) u_cell (
			.clk    (clk),
			.en     (en[2+k]),
			.rem_i  (rem_c[k]),
			.root_i (root_c[k]),
			.rad_i  (rad_c[k]),
			.side_i (sside_c[k]),
			.rem_q  (rem_c[k+1]),
			.root_q (root_c[k+1]),
			.rad_q  (rad_c[k+1]),
			.side_q (sside_c[k+1])
		);
	end

	// CORDIC chain of CS cells, starting vector with 8 fractional bits.
	logic signed [W-1:0]  x_c [CS+1];
	logic signed [W-1:0]  y_c [CS+1];
	logic signed [ZW-1:0] z_c [CS+1];
	logic [SPW-1:0]       cside_c [CS+1];
	logic signed [DW-1:0] a_root;

	assign a_root     = signed'(sside_c[QB][DW-1:0]);
	assign x_c[0]     = signed'(W'(root_c[QB]));
	assign y_c[0]     = W'(signed'({a_root, 8'b0}));
	assign z_c[0]     = '0;
	assign cside_c[0] = sside_c[QB][SW-1:DW];

	for (genvar j = 0; j < CS; j++) begin : g_cordic
		att_cordic_cell #(.W(W), .IDX(j), .SW(SPW)) u_cell (
			.clk    (clk),
			.en     (en[QB+2+j]),
			.x_i    (x_c[j]),
			.y_i    (y_c[j]),
			.z_i    (z_c[j]),
			.side_i (cside_c[j]),
			.x_q    (x_c[j+1]),
			.y_q    (y_c[j+1]),
			.z_q    (z_c[j+1]),
			.side_q (cside_c[j+1])
		);
	end

	// Truncate toward zero to whole degrees and clamp.
	logic signed [ZW-1:0]             zf;
	logic signed [ZW-1:0]             zmag;
	logic signed [ZW-1:0]             whole;
	logic signed [att_pkg::DEG_W-1:0] deg;

	always_comb begin
		zf    = z_c[CS];
		zmag  = (zf < 0) ? -zf : zf;
		whole = zmag >>> att_pkg::FRAC;
		if (zf < 0) begin
			whole = -whole;
		end
		if (whole > ZW'(att_pkg::DEG_POS)) begin
			deg = att_pkg::DEG_POS;
		end else if (whole < ZW'(att_pkg::DEG_NEG)) begin
			deg = att_pkg::DEG_NEG;
		end else begin
			deg = whole[att_pkg::DEG_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[LAST]) begin
			deg_q <= cside_c[CS][SPW-1] ? signed'(cside_c[CS][SPW-2:0]) : deg;
		end
	end

endmodule

@@ rtl/core/accel_tilt_angles.sv @@
// Three-axis accelerometer tilt angles.
// A request on the input channel (in_valid/in_ready) carries one sample accel_x, accel_y,
// accel_z in signed milli-g. The per-axis offsets are subtracted and pitch, roll and yaw
// are returned as whole degrees in -90..90, truncated toward zero, on the output channel
// (out_valid/out_ready), one result per request, in order.
// Offsets are written through cfg_valid/cfg_ready with cfg_index 0, 1, 2 for x, y, z;
// index 3 is ignored. cfg_ready is always high. Write only while the block is idle.
// The pipeline has one stage for the offset subtract, one for the squares, one per root bit
// of the digit-serial square root chain, one per CORDIC cell and one output register.
// Throughput is one request per cycle while the receiver does not stall. Each stage moves on
// when it is empty or the next stage moves, so a stalled receiver fills bubbles first and
// only then holds in_ready low.
// Reset clears all stage valid bits and loads the offsets with -18, 90 and 26.
module accel_tilt_angles #(
	parameter int CORDIC_STAGES = 16,
	parameter int SAMPLE_BITS = 13
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [SAMPLE_BITS-1:0]    accel_x,
	input  logic signed [SAMPLE_BITS-1:0]    accel_y,
	input  logic signed [SAMPLE_BITS-1:0]    accel_z,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [att_pkg::DEG_W-1:0] pitch_deg,
	output logic signed [att_pkg::DEG_W-1:0] roll_deg,
	output logic signed [att_pkg::DEG_W-1:0] yaw_deg,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [1:0]                       cfg_index,
	input  logic signed [att_pkg::OFS_W-1:0] cfg_data
);

	localparam int DW = ((SAMPLE_BITS > att_pkg::OFS_W) ? SAMPLE_BITS : att_pkg::OFS_W) + 1;
	localparam int L = DW + 8 + CORDIC_STAGES + 3;

	logic signed [att_pkg::OFS_W-1:0] ofs_x_q;
	logic signed [att_pkg::OFS_W-1:0] ofs_y_q;
	logic signed [att_pkg::OFS_W-1:0] ofs_z_q;

	// Offset registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofs_x_q <= -10'sd18;
			ofs_y_q <= 10'sd90;
			ofs_z_q <= 10'sd26;
		end else if (cfg_valid) begin
			case (att_pkg::reg_idx_t'(cfg_index))
				att_pkg::REG_OFS_X: ofs_x_q <= cfg_data;
				att_pkg::REG_OFS_Y: ofs_y_q <= cfg_data;
				att_pkg::REG_OFS_Z: ofs_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage valid bits and per-stage advance.
	logic [L-1:0] v_q;
	logic [L-1:0] adv;

	always_comb begin
		adv[L-1] = !v_q[L-1] || out_ready;
		for (int k = L - 2; k >= 0; k--) begin
			adv[k] = !v_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (adv[0]) begin
				v_q[0] <= in_valid;
			end
			for (int k = 1; k < L; k++) begin
				if (adv[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = v_q[L-1];

	// Offset subtract.
	logic signed [DW-1:0] ax_s0;
	logic signed [DW-1:0] ay_s0;
	logic signed [DW-1:0] az_s0;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			ax_s0 <= DW'(accel_x) - DW'(ofs_x_q);
			ay_s0 <= DW'(accel_y) - DW'(ofs_y_q);
			az_s0 <= DW'(accel_z) - DW'(ofs_z_q);
		end
	end

	// One lane per angle.
	att_lane #(.DW(DW), .CS(CORDIC_STAGES)) u_pitch (
		.clk   (clk),
		.en    (adv[L-1:1]),
		.a     (ax_s0),
		.b     (ay_s0),
		.c     (az_s0),
		.deg_q (pitch_deg)
	);

	att_lane #(.DW(DW), .CS(CORDIC_STAGES)) u_roll (
		.clk   (clk),
		.en    (adv[L-1:1]),
		.a     (ay_s0),
		.b     (ax_s0),
		.c     (az_s0),
		.deg_q (roll_deg)
	);

	att_lane #(.DW(DW), .CS(CORDIC_STAGES)) u_yaw (
		.clk   (clk),
		.en    (adv[L-1:1]),
		.a     (az_s0),
		.b     (ay_s0),
		.c     (ax_s0),
		.deg_q (yaw_deg)
	);

endmodule
